FILE: rtl/ldf_pkg.sv
// Shared types, constants and the CRC-8 step function for the lidar packet deframer.
// Used by ldf_collect, ldf_emit and lidar_packet_deframer_unit; depends on nothing else.
package ldf_pkg;

    // Fixed field widths
    localparam int IDX_W  = 5;
    localparam int WORD_W = 16;

    // Angle arithmetic in hundredths of a degree
    localparam int ANGLE_FULL = 36000;
    localparam int SPAN_W     = 18;
    localparam int SUM_W      = 17;

    // CRC-8, MSB first, no reflection
    localparam logic [7:0] CRC_POLY = 8'h4D;

    // Configuration registers
    localparam int         CFG_IDX_W     = 2;
    localparam logic [1:0] CFG_HEADER    = 2'd0;
    localparam logic [1:0] CFG_VER_LEN   = 2'd1;
    localparam logic [7:0] HEADER_RESET  = 8'd84;
    localparam logic [7:0] VER_LEN_RESET = 8'd44;

    // Result kinds
    localparam logic STATUS_POINT   = 1'b0;
    localparam logic STATUS_CRC_ERR = 1'b1;

    // Frame status from the collector to the emitter
    typedef struct packed {
        logic              at_final;
        logic              done;
        logic              crc_ok;
        logic [WORD_W-1:0] speed;
        logic [WORD_W-1:0] first_angle;
        logic [WORD_W-1:0] last_angle;
        logic [WORD_W-1:0] stamp;
    } t_frame_info;

    // One result item
    typedef struct packed {
        logic              status_code;
        logic [WORD_W-1:0] speed;
        logic [WORD_W-1:0] first_angle;
        logic [WORD_W-1:0] last_angle;
        logic [WORD_W-1:0] stamp;
        logic [IDX_W-1:0]  point_index;
        logic [WORD_W-1:0] distance;
        logic [7:0]        intensity;
        logic [WORD_W-1:0] point_angle;
        logic              last;
    } t_result;

    // Advance the CRC by one byte
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

FILE: rtl/ldf_frame_ram.sv
// Frame byte store: one write port, one read port with registered read data.
// Generic; no package dependency.
module ldf_frame_ram #(
    parameter int DEPTH  = 47,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/ldf_collect.sv
// Header hunt, frame byte collection, CRC-8 and capture of the frame-wide fields.
// Depends on ldf_pkg; writes frame bytes into ldf_frame_ram.
module ldf_collect #(
    parameter int POINTS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic [7:0]                          i_byte,
    input  logic [7:0]                          i_header,
    input  logic [7:0]                          i_ver_len,
    output logic                                o_mem_we,
    output logic [$clog2(11+3*POINTS)-1:0]      o_mem_addr,
    output logic [7:0]                          o_mem_data,
    output ldf_pkg::t_frame_info                o_info
);

    localparam int FRAME_LEN = 11 + 3 * POINTS;
    localparam int AW        = $clog2(FRAME_LEN);

    localparam logic [1:0] HUNT_HDR = 2'd0;
    localparam logic [1:0] HUNT_VER = 2'd1;
    localparam logic [1:0] COLLECT  = 2'd2;

    logic [1:0]    r_hunt,  n_hunt;
    logic [AW-1:0] r_count, n_count;
    logic [7:0]    r_crc,   n_crc;
    logic [15:0]   r_speed, r_start, r_end, r_stamp;
    logic          at_final, done, crc_ok, we;

    // Hunt and collect sequencing
    always_comb begin
        n_hunt   = r_hunt;
        n_count  = r_count;
        n_crc    = r_crc;
        done     = 1'b0;
        crc_ok   = 1'b0;
        we       = 1'b0;
        at_final = (r_hunt == COLLECT) && (r_count == AW'(FRAME_LEN - 1));
        if (i_accept) begin
            unique case (r_hunt)
                HUNT_VER: begin
                    if (i_byte == i_ver_len) begin
                        n_crc   = ldf_pkg::crc8_next(ldf_pkg::crc8_next(8'h00, i_header),
                                                     i_byte);
                        n_count = AW'(2);
                        n_hunt  = COLLECT;
                    end else begin
                        n_hunt = HUNT_HDR;
                    end
                end
                COLLECT: begin
                    we = 1'b1;
                    if (at_final) begin
                        // final byte carries the CRC: compare, do not fold in
                        done    = 1'b1;
                        crc_ok  = (r_crc == i_byte);
                        n_hunt  = HUNT_HDR;
                        n_count = '0;
                    end else begin
                        n_crc   = ldf_pkg::crc8_next(r_crc, i_byte);
                        n_count = r_count + AW'(1);
                    end
                end
                default: begin
                    // hunting header, unused code included
                    n_hunt = (i_byte == i_header) ? HUNT_VER : HUNT_HDR;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hunt  <= HUNT_HDR;
            r_count <= '0;
            r_crc   <= '0;
        end else begin
            r_hunt  <= n_hunt;
            r_count <= n_count;
            r_crc   <= n_crc;
        end
    end

    // Capture the little-endian frame-wide fields as they pass
    always_ff @(posedge i_clk) begin
        if (we) begin
            if (r_count == AW'(2))             r_speed[7:0]  <= i_byte;
            if (r_count == AW'(3))             r_speed[15:8] <= i_byte;
            if (r_count == AW'(4))             r_start[7:0]  <= i_byte;
            if (r_count == AW'(5))             r_start[15:8] <= i_byte;
            if (r_count == AW'(FRAME_LEN - 5)) r_end[7:0]    <= i_byte;
            if (r_count == AW'(FRAME_LEN - 4)) r_end[15:8]   <= i_byte;
            if (r_count == AW'(FRAME_LEN - 3)) r_stamp[7:0]  <= i_byte;
            if (r_count == AW'(FRAME_LEN - 2)) r_stamp[15:8] <= i_byte;
        end
    end

    assign o_mem_we   = we;
    assign o_mem_addr = r_count;
    assign o_mem_data = i_byte;

    always_comb begin
        o_info.at_final    = at_final;
        o_info.done        = done;
        o_info.crc_ok      = crc_ok;
        o_info.speed       = r_speed;
        o_info.first_angle = r_start;
        o_info.last_angle  = r_end;
        o_info.stamp       = r_stamp;
    end

endmodule

FILE: rtl/ldf_emit.sv
// Result sequencer: angle span, span/(POINTS-1) by reciprocal multiplication, frame store
// reads and the output register. Depends on ldf_pkg; reads ldf_frame_ram.
module ldf_emit #(
    parameter int POINTS = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ldf_pkg::t_frame_info           i_info,
    input  logic                           i_ready,
    output logic                           o_idle,
    output logic                           o_rd_en,
    output logic [$clog2(11+3*POINTS)-1:0] o_rd_addr,
    input  logic [7:0]                     i_rd_data,
    output logic                           o_valid,
    output ldf_pkg::t_result               o_result
);

    localparam int FRAME_LEN = 11 + 3 * POINTS;
    localparam int AW        = $clog2(FRAME_LEN);
    localparam int DIV_W     = $clog2(POINTS);
    localparam int DIVISOR   = POINTS - 1;
    localparam int W         = ldf_pkg::WORD_W;
    localparam int IW        = ldf_pkg::IDX_W;
    localparam int SPAN_W    = ldf_pkg::SPAN_W;
    localparam int SUM_W     = ldf_pkg::SUM_W;
    // Reciprocal exact for every 16-bit span: shift 16 + ceil(log2 divisor)
    localparam int RECIP_SH  = W + $clog2(DIVISOR);
    localparam int RECIP_W   = W + 1;
    localparam int PROD_W    = W + RECIP_SH;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((2 ** RECIP_SH + DIVISOR - 1) / DIVISOR);
    localparam logic [IW-1:0] LAST_IDX = IW'(POINTS - 1);

    localparam logic [2:0] E_IDLE = 3'd0;
    localparam logic [2:0] E_SPAN = 3'd1;
    localparam logic [2:0] E_DIV  = 3'd2;
    localparam logic [2:0] E_P0   = 3'd3;
    localparam logic [2:0] E_P1   = 3'd4;
    localparam logic [2:0] E_P2   = 3'd5;
    localparam logic [2:0] E_P3   = 3'd6;

    logic [2:0]                r_state, n_state;
    logic                      r_out_valid, n_out_valid;
    logic [SPAN_W-1:0]         r_x;
    logic [W-1:0]              r_quo;
    logic [DIV_W-1:0]          r_rem;
    logic                      r_div_cnt;
    logic [W-1:0]              r_q;
    logic [DIV_W-1:0]          r_r;
    logic [IW-1:0]             r_idx;
    logic [AW-1:0]             r_base;
    logic [SUM_W-1:0]          r_sum;
    logic [7:0]                r_dist_lo, r_dist_hi;
    logic [W-1:0]              r_speed, r_start, r_end, r_stamp;
    ldf_pkg::t_result          r_out;

    logic                      out_free, load_point, is_last, span_ge;
    logic [PROD_W-1:0]         recip_prod;
    logic [W-1:0]              quo_new, rem_full;
    logic [DIV_W-1:0]          rem_new;
    logic [DIV_W:0]            rr_sum;
    logic                      rr_wrap;
    logic [DIV_W-1:0]          rr_new;
    logic [SUM_W-1:0]          ang_full;
    logic [W-1:0]              ang;
    ldf_pkg::t_result          err_result;

    // Quotient by reciprocal multiplication, remainder by multiplying back
    always_comb begin
        recip_prod = PROD_W'(r_x[W-1:0]) * PROD_W'(RECIP);
        quo_new    = recip_prod[PROD_W-1:RECIP_SH];
        rem_full   = r_x[W-1:0] - r_quo * W'(DIVISOR);
        rem_new    = DIV_W'(rem_full);
    end

    // Running quotient and remainder of idx*span/(POINTS-1)
    always_comb begin
        rr_sum  = {1'b0, r_r} + {1'b0, r_rem};
        rr_wrap = rr_sum >= (DIV_W + 1)'(DIVISOR);
        rr_new  = rr_wrap ? DIV_W'(rr_sum - (DIV_W + 1)'(DIVISOR)) : DIV_W'(rr_sum);
    end

    // Fold the point angle back into the circle
    always_comb begin
        if (r_sum > SUM_W'(2 * ldf_pkg::ANGLE_FULL)) begin
            ang_full = r_sum - SUM_W'(2 * ldf_pkg::ANGLE_FULL);
        end else if (r_sum > SUM_W'(ldf_pkg::ANGLE_FULL)) begin
            ang_full = r_sum - SUM_W'(ldf_pkg::ANGLE_FULL);
        end else begin
            ang_full = r_sum;
        end
        ang = ang_full[W-1:0];
    end

    // CRC error item: all fields zero but the status and the last flag
    always_comb begin
        err_result             = '0;
        err_result.status_code = ldf_pkg::STATUS_CRC_ERR;
        err_result.last        = 1'b1;
    end

    assign span_ge  = r_x >= SPAN_W'(ldf_pkg::ANGLE_FULL);
    assign out_free = !r_out_valid || i_ready;
    assign is_last  = (r_idx == LAST_IDX);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_ready;
        load_point  = 1'b0;
        unique case (r_state)
            E_IDLE: begin
                if (i_info.done) begin
                    if (i_info.crc_ok) begin
                        n_state = E_SPAN;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            E_SPAN: if (!span_ge)  n_state = E_DIV;
            E_DIV:  if (r_div_cnt) n_state = E_P0;
            E_P0:   n_state = E_P1;
            E_P1:   n_state = E_P2;
            E_P2:   n_state = E_P3;
            E_P3: begin
                if (out_free) begin
                    load_point  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = is_last ? E_IDLE : E_P0;
                end
            end
            default: n_state = E_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= E_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            E_IDLE: begin
                if (i_info.done) begin
                    r_speed <= i_info.speed;
                    r_start <= i_info.first_angle;
                    r_end   <= i_info.last_angle;
                    r_stamp <= i_info.stamp;
                    r_x     <= SPAN_W'({2'b00, i_info.last_angle})
                             + SPAN_W'(2 * ldf_pkg::ANGLE_FULL)
                             - SPAN_W'({2'b00, i_info.first_angle});
                    if (!i_info.crc_ok) begin
                        r_out <= err_result;
                    end
                end
            end
            E_SPAN: begin
                if (span_ge) begin
                    r_x <= r_x - SPAN_W'(ldf_pkg::ANGLE_FULL);
                end else begin
                    r_div_cnt <= 1'b0;
                end
            end
            E_DIV: begin
                // quotient first, then the remainder from the registered quotient
                if (!r_div_cnt) begin
                    r_quo <= quo_new;
                end else begin
                    r_rem <= rem_new;
                end
                r_div_cnt <= 1'b1;
                r_q       <= '0;
                r_r       <= '0;
                r_idx     <= '0;
                r_base    <= AW'(6);
            end
            E_P0: r_sum     <= SUM_W'(r_start) + SUM_W'(r_q);
            E_P1: r_dist_lo <= i_rd_data;
            E_P2: r_dist_hi <= i_rd_data;
            E_P3: begin
                if (load_point) begin
                    r_out.status_code <= ldf_pkg::STATUS_POINT;
                    r_out.speed       <= r_speed;
                    r_out.first_angle <= r_start;
                    r_out.last_angle  <= r_end;
                    r_out.stamp       <= r_stamp;
                    r_out.point_index <= r_idx;
                    r_out.distance    <= {r_dist_hi, r_dist_lo};
                    r_out.intensity   <= i_rd_data;
                    r_out.point_angle <= ang;
                    r_out.last        <= is_last;
                    // advance to the next point
                    r_idx  <= r_idx + IW'(1);
                    r_base <= r_base + AW'(3);
                    r_q    <= r_q + r_quo + W'(rr_wrap);
                    r_r    <= rr_new;
                end
            end
            default: ;
        endcase
    end

    // Distance low, distance high, intensity: one frame store read each
    always_comb begin
        o_rd_en   = (r_state == E_P0) || (r_state == E_P1) || (r_state == E_P2);
        o_rd_addr = r_base;
        if (r_state == E_P1) o_rd_addr = r_base + AW'(1);
        if (r_state == E_P2) o_rd_addr = r_base + AW'(2);
    end

    assign o_idle   = (r_state == E_IDLE);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

FILE: rtl/lidar_packet_deframer_unit.sv
// Top level of the lidar packet deframer: configuration registers, handshakes and glue.
// Depends on ldf_pkg, ldf_frame_ram, ldf_collect and ldf_emit.
//
//  channel   direction  width  contents
//  s_axis    in         8      raw link byte
//  m_axis    out        112    one point result or one CRC error result per item
//  cfg       in         8      header byte (index 0), version/length byte (index 1)
//
// Input bytes are taken one per cycle while hunting and collecting; the final byte waits
// while an output item is held. The final byte of a good frame stops the input while the
// span is reduced and divided and, per point, for three frame store reads and one output
// load, longer while m_axis_tready is low. A failed frame gives one item on the next
// cycle. Reset (i_rst_n low at a clock edge) restores the configuration and the hunt
// state; the frame store keeps its contents and is written before it is read.
module lidar_packet_deframer_unit #(
    parameter int POINTS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // byte_in
    // master stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // speed, first angle, last angle, stamp, point_index, distance, intensity,
    // point_angle, zero pad
    output logic [111:0]                      m_axis_tdata,
    output logic                              m_axis_tuser,   // status_code
    output logic                              m_axis_tlast,   // last
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [ldf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [7:0]                        i_cfg_data
);

    localparam int FRAME_LEN = 11 + 3 * POINTS;
    localparam int AW        = $clog2(FRAME_LEN);

    logic [7:0]           r_header, r_ver_len;
    logic                 accept, idle, mem_we, rd_en, out_valid;
    logic [AW-1:0]        mem_addr, rd_addr;
    logic [7:0]           mem_data, rd_data;
    ldf_pkg::t_frame_info info;
    ldf_pkg::t_result     result;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header  <= ldf_pkg::HEADER_RESET;
            r_ver_len <= ldf_pkg::VER_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ldf_pkg::CFG_HEADER:  r_header  <= i_cfg_data;
                ldf_pkg::CFG_VER_LEN: r_ver_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input only while the emitter is idle; the final byte waits while an item is held
    assign s_axis_tready = idle && !(info.at_final && out_valid);
    assign accept        = s_axis_tvalid && s_axis_tready;

    ldf_collect #(
        .POINTS (POINTS)
    ) u_collect (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_byte     (s_axis_tdata),
        .i_header   (r_header),
        .i_ver_len  (r_ver_len),
        .o_mem_we   (mem_we),
        .o_mem_addr (mem_addr),
        .o_mem_data (mem_data),
        .o_info     (info)
    );

    ldf_frame_ram #(
        .DEPTH  (FRAME_LEN),
        .ADDR_W (AW),
        .DATA_W (8)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_addr),
        .i_wdata (mem_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    ldf_emit #(
        .POINTS (POINTS)
    ) u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_info    (info),
        .i_ready   (m_axis_tready),
        .o_idle    (idle),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_valid   (out_valid),
        .o_result  (result)
    );

    // Pack the result item
    assign m_axis_tvalid = out_valid;
    assign m_axis_tuser  = result.status_code;
    assign m_axis_tlast  = result.last;
    assign m_axis_tdata  = {3'b000, result.point_angle, result.intensity, result.distance,
                            result.point_index, result.stamp, result.last_angle,
                            result.first_angle, result.speed};

endmodule
